FILE: rtl/lifo_free_list_slot_allocator_unit_macros.svh
// ----------------------------------------------------------------------------
// lifo free-list slot allocator assertion macros
// shared property wrappers for the checker
// ----------------------------------------------------------------------------
`ifndef LIFO_FREE_LIST_SLOT_ALLOCATOR_UNIT_MACROS_SVH
`define LIFO_FREE_LIST_SLOT_ALLOCATOR_UNIT_MACROS_SVH

// same-cycle implication
`define LFSA_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define LFSA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/lfsa_pkg.sv
// ----------------------------------------------------------------------------
// lfsa_pkg
// types and codes for the lifo free-list slot allocator
// ----------------------------------------------------------------------------
package lfsa_pkg;

  localparam int unsigned SLOT_W   = 9;
  localparam int unsigned STATUS_W = 2;

  localparam logic KIND_OCCUPY  = 1'b0;
  localparam logic KIND_RELEASE = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_RANGE = 2'd2,
    ST_FREE  = 2'd3
  } lfsa_status_t;

  typedef struct packed {
    logic              kind;
    logic [SLOT_W-1:0] slot_index;
  } lfsa_in_t;

  typedef struct packed {
    logic [SLOT_W-1:0] assigned_slot;
    lfsa_status_t      status;
  } lfsa_out_t;

endpackage

FILE: rtl/lifo_free_list_slot_allocator_unit.sv
// ----------------------------------------------------------------------------
// lifo_free_list_slot_allocator_unit
// hands out 1-based slots from a lifo chain of released slots, creating
// new slots when the chain is empty; checks releases for range and state
// ----------------------------------------------------------------------------
//  channel  direction  payload     handshake
//  in_      input      lfsa_in_t   in_valid / in_ready
//  out_     output     lfsa_out_t  out_valid / out_ready
//
//  one item at a time: the accept cycle reads the link and in-use memories
//  (synchronous read), the decide cycle then decides and writes back.
//  a pop needs the head's link from the link memory before the next item.
//  rst_n is synchronous; afterwards the chain is empty, no slot exists.
//  a waiting result holds the item in its decide cycle; in_ready stays low.
// ----------------------------------------------------------------------------
module lifo_free_list_slot_allocator_unit
  import lfsa_pkg::*;
#(
  parameter int unsigned SLOTS = 256
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  lfsa_in_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output lfsa_out_t out_data
);

  localparam int unsigned AW = $clog2(SLOTS);
  localparam int unsigned CW = $clog2(SLOTS + 1);

  logic              busy_r;
  lfsa_in_t          in_r;
  logic [SLOT_W-1:0] head_r, head_nxt;
  logic [CW-1:0]     created_r, created_nxt;
  logic              out_valid_r;
  lfsa_out_t         out_r, res_nxt;
  logic [SLOT_W-1:0] link_rd_r;
  logic              use_rd_r;

  logic [SLOT_W-1:0] link_mem [SLOTS];
  logic              use_mem  [SLOTS];

  logic              accept, done;
  logic [CW-1:0]     created_inc;
  logic [SLOT_W-1:0] head_m1, idx_m1, in_idx_m1;
  logic              head_ok, room, idx_bad;
  logic              link_we, use_we, use_wd;
  logic [AW-1:0]     link_wa, use_wa;
  logic [SLOT_W-1:0] link_wd;

  assign in_ready  = !busy_r;
  assign accept    = in_valid && !busy_r;
  assign done      = busy_r && (!out_valid_r || out_ready);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  assign created_inc = created_r + CW'(1);
  assign head_m1     = head_r - SLOT_W'(1);
  assign idx_m1      = in_r.slot_index - SLOT_W'(1);
  assign in_idx_m1   = in_data.slot_index - SLOT_W'(1);

  assign head_ok = (head_r != '0) && (32'(head_r) <= SLOTS);
  assign room    = 32'(created_r) < SLOTS;
  assign idx_bad = (in_r.slot_index == '0) || (32'(in_r.slot_index) > 32'(created_r)) ||
                   (32'(in_r.slot_index) > SLOTS);

  always_comb begin
    res_nxt.assigned_slot = '0;
    res_nxt.status        = ST_OK;
    head_nxt              = head_r;
    created_nxt           = created_r;
    link_we               = 1'b0;
    link_wa               = AW'(idx_m1);
    link_wd               = head_r;
    use_we                = 1'b0;
    use_wa                = AW'(idx_m1);
    use_wd                = 1'b0;
    if (in_r.kind == KIND_OCCUPY) begin
      if (head_ok) begin
        // pop the chain head; its link was read in the accept cycle
        res_nxt.assigned_slot = head_r;
        head_nxt              = link_rd_r;
        use_we                = 1'b1;
        use_wa                = AW'(head_m1);
        use_wd                = 1'b1;
      end else if (room) begin
        res_nxt.assigned_slot = SLOT_W'(created_inc);
        created_nxt           = created_inc;
        use_we                = 1'b1;
        use_wa                = AW'(created_r);
        use_wd                = 1'b1;
      end else begin
        res_nxt.status = ST_FULL;
      end
    end else begin
      if (idx_bad) begin
        res_nxt.status = ST_RANGE;
      end else if (!use_rd_r) begin
        res_nxt.status = ST_FREE;
      end else begin
        // push onto the chain
        link_we  = 1'b1;
        use_we   = 1'b1;
        head_nxt = in_r.slot_index;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      head_r      <= '0;
      created_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        busy_r <= 1'b1;
      end else if (done) begin
        busy_r <= 1'b0;
      end
      if (done) begin
        head_r    <= head_nxt;
        created_r <= created_nxt;
      end
      if (done) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      in_r <= in_data;
    end
    if (done) begin
      out_r <= res_nxt;
    end
  end

  // entries up to the created count are always written before they are read
  always_ff @(posedge clk) begin
    if (accept) begin
      link_rd_r <= link_mem[AW'(head_m1)];
      use_rd_r  <= use_mem[AW'(in_idx_m1)];
    end
    if (done && link_we) begin
      link_mem[link_wa] <= link_wd;
    end
    if (done && use_we) begin
      use_mem[use_wa] <= use_wd;
    end
  end

endmodule

FILE: rtl/lfsa_checker.sv
// ----------------------------------------------------------------------------
// lfsa_checker
// port-level checks for the lifo free-list slot allocator
// ----------------------------------------------------------------------------
`include "lifo_free_list_slot_allocator_unit_macros.svh"

module lfsa_checker
  import lfsa_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_ready,
  input lfsa_in_t  in_data,
  input logic      out_valid,
  input logic      out_ready,
  input lfsa_out_t out_data
);

  // a beat stays on the output until taken
  `LFSA_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid, "out beat dropped")

  // one item in flight: no accept right after an accept
  `LFSA_ASSERT_NEXT(a_one_inflight, clk, rst_n, in_valid && in_ready, !in_ready, "back-to-back accept")

  // in_ready only drops after an accepted beat
  `LFSA_ASSERT_NOW(a_ready_fall, clk, rst_n, $fell(in_ready), $past(in_valid && in_ready), "in_ready fell without accept")

  // any error result carries no slot
  `LFSA_ASSERT_NOW(a_err_no_slot, clk, rst_n, out_valid && (out_data.status != ST_OK), out_data.assigned_slot == '0, "error result with slot")

endmodule

bind lifo_free_list_slot_allocator_unit lfsa_checker u_lfsa_checker (.*);

FILE: bench/lifo_free_list_slot_allocator_unit_tb.sv
// ----------------------------------------------------------------------------
// lifo_free_list_slot_allocator_unit_tb
// drives occupy and release beats into the slot allocator and checks every
// result against fixed expected rows or a scoreboard model of the free chain and the in-use flags
// ----------------------------------------------------------------------------
module lifo_free_list_slot_allocator_unit_tb;
  import lfsa_pkg::*;

  localparam int unsigned SLOTS = 256;
  localparam int unsigned RAND_SEGMENTS = 8;
  localparam int unsigned SEGMENT_BEATS = 170;
  localparam int unsigned MAX_REPORTS = 100;

  typedef struct {
    lfsa_in_t  beat;
    bit        typed;
    lfsa_out_t want;
  } stim_row_t;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  lfsa_in_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  lfsa_out_t out_data;

  // side info held with the payload of the current beat
  bit        beat_typed = 1'b0;
  lfsa_out_t beat_want = '0;

  int unsigned send_idle = 0;
  int unsigned recv_stall = 0;
  int unsigned fail_count = 0;

  // allocator model
  logic [SLOT_W-1:0] link_mem [1:SLOTS];
  bit                slot_busy [1:SLOTS];
  int unsigned       chain_head;
  int unsigned       created_count;

  lfsa_out_t result_q [$];
  stim_row_t dir_rows [$];

  lifo_free_list_slot_allocator_unit #(.SLOTS(SLOTS)) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #2000000;
    $display("lifo_free_list_slot_allocator_unit verification failed");
    $finish;
  end

  task automatic report_mismatch(input string msg);
    if (fail_count < MAX_REPORTS) begin
      $display("MISMATCH at %0t: %s", $realtime, msg);
    end
    fail_count++;
  endtask

  function automatic lfsa_out_t predict_alloc(input lfsa_in_t beat);
    lfsa_out_t   res;
    int unsigned idx;
    res.assigned_slot = '0;
    res.status = ST_OK;
    idx = 32'(beat.slot_index);
    if (beat.kind == KIND_OCCUPY) begin
      if (chain_head != 0) begin
        res.assigned_slot = chain_head[SLOT_W-1:0];
        slot_busy[chain_head] = 1'b1;
        chain_head = 32'(link_mem[chain_head]);
      end else if (created_count < SLOTS) begin
        created_count++;
        res.assigned_slot = created_count[SLOT_W-1:0];
        slot_busy[created_count] = 1'b1;
      end else begin
        res.status = ST_FULL;
      end
    end else begin
      if (idx == 0 || idx > created_count) begin
        res.status = ST_RANGE;
      end else if (!slot_busy[idx]) begin
        res.status = ST_FREE;
      end else begin
        link_mem[idx] = chain_head[SLOT_W-1:0];
        chain_head = idx;
        slot_busy[idx] = 1'b0;
      end
    end
    return res;
  endfunction

  // k-th created slot whose busy flag matches, picked at random; 0 if none
  function automatic int unsigned pick_slot(input bit want_busy);
    int unsigned hits;
    int unsigned k;
    hits = 0;
    for (int unsigned s = 1; s <= created_count; s++) begin
      if (slot_busy[s] == want_busy) hits++;
    end
    if (hits == 0) return 0;
    k = $urandom_range(hits - 1);
    for (int unsigned s = 1; s <= created_count; s++) begin
      if (slot_busy[s] == want_busy) begin
        if (k == 0) return s;
        k--;
      end
    end
    return 0;
  endfunction

  function automatic lfsa_in_t random_beat(input int unsigned occupy_pct);
    lfsa_in_t    b;
    int unsigned r;
    int unsigned s;
    b.slot_index = SLOT_W'($urandom);
    if ($urandom_range(99) < occupy_pct) begin
      b.kind = KIND_OCCUPY;
    end else begin
      b.kind = KIND_RELEASE;
      r = $urandom_range(99);
      s = 0;
      if (r < 65) begin
        s = pick_slot(1'b1);
      end else if (r < 80) begin
        s = pick_slot(1'b0);
      end else if (r < 90) begin
        case ($urandom_range(3))
          0: s = 0;
          1: s = created_count;
          2: s = created_count + 1;
          default: s = SLOTS;
        endcase
        b.slot_index = s[SLOT_W-1:0];
      end
      if (r < 80 && s != 0) b.slot_index = s[SLOT_W-1:0];
    end
    return b;
  endfunction

  task automatic add_row(input logic kind, input int unsigned idx, input bit typed,
                         input int unsigned slot, input lfsa_status_t st);
    stim_row_t row;
    row.beat.kind = kind;
    row.beat.slot_index = idx[SLOT_W-1:0];
    row.typed = typed;
    row.want.assigned_slot = slot[SLOT_W-1:0];
    row.want.status = st;
    dir_rows.push_back(row);
  endtask

  // called at a falling edge; returns at the falling edge after acceptance
  task automatic send_beat(input lfsa_in_t beat, input bit typed, input lfsa_out_t want);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= beat;
    beat_typed <= typed;
    beat_want <= want;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  task automatic wait_drained;
    in_valid <= 1'b0;
    while (result_q.size() != 0) @(negedge clk);
  endtask

  always @(negedge clk) begin
    out_ready <= (recv_stall == 0) ? 1'b1 : ($urandom_range(99) >= recv_stall);
  end

  // accept side feeds the model, result side pops and compares
  always @(posedge clk) begin
    lfsa_out_t pred;
    lfsa_out_t want;
    if (rst_n && in_valid && in_ready) begin
      pred = predict_alloc(in_data);
      result_q.push_back(beat_typed ? beat_want : pred);
    end
    if (rst_n && out_valid && out_ready) begin
      if (result_q.size() == 0) begin
        report_mismatch($sformatf("result beat with nothing expected: slot %0d status %0d",
                                  out_data.assigned_slot, out_data.status));
      end else begin
        want = result_q.pop_front();
        if (out_data.assigned_slot !== want.assigned_slot)
          report_mismatch($sformatf("assigned_slot got %0d want %0d",
                                    out_data.assigned_slot, want.assigned_slot));
        if (out_data.status !== want.status)
          report_mismatch($sformatf("status got %0d want %0d (slot %0d)",
                                    out_data.status, want.status, want.assigned_slot));
      end
    end
  end

  initial begin
    lfsa_out_t   none;
    lfsa_in_t    b;
    int unsigned occupy_pct [RAND_SEGMENTS];
    int unsigned idle_send [4];
    int unsigned idle_recv [4];

    occupy_pct = '{60, 90, 95, 40, 20, 70, 95, 50};
    idle_send = '{0, 88, 0, 14};
    idle_recv = '{0, 0, 88, 14};
    none = '0;
    for (int unsigned s = 1; s <= SLOTS; s++) begin
      link_mem[s] = '0;
      slot_busy[s] = 1'b0;
    end
    chain_head = 0;
    created_count = 0;

    // releases before any slot exists, then a short lifo walk
    add_row(KIND_RELEASE, 0,     1, 0, ST_RANGE);
    add_row(KIND_RELEASE, 1,     1, 0, ST_RANGE);
    add_row(KIND_RELEASE, 511,   1, 0, ST_RANGE);
    add_row(KIND_OCCUPY,  511,   1, 1, ST_OK);
    add_row(KIND_OCCUPY,  0,     1, 2, ST_OK);
    add_row(KIND_OCCUPY,  0,     1, 3, ST_OK);
    add_row(KIND_RELEASE, 2,     1, 0, ST_OK);
    add_row(KIND_RELEASE, 2,     1, 0, ST_FREE);
    add_row(KIND_RELEASE, 4,     1, 0, ST_RANGE);
    add_row(KIND_RELEASE, 3,     0, 0, ST_OK);
    add_row(KIND_OCCUPY,  0,     0, 0, ST_OK);
    add_row(KIND_OCCUPY,  0,     0, 0, ST_OK);
    add_row(KIND_OCCUPY,  0,     0, 0, ST_OK);
    add_row(KIND_RELEASE, 1,     0, 0, ST_OK);
    add_row(KIND_RELEASE, 4,     0, 0, ST_OK);
    add_row(KIND_RELEASE, 3,     0, 0, ST_OK);
    add_row(KIND_OCCUPY,  'h0AA, 0, 0, ST_OK);
    add_row(KIND_OCCUPY,  'h155, 0, 0, ST_OK);
    add_row(KIND_OCCUPY,  'h1FF, 0, 0, ST_OK);
    add_row(KIND_RELEASE, 256,   1, 0, ST_RANGE);
    add_row(KIND_RELEASE, 'h0AA, 1, 0, ST_RANGE);
    add_row(KIND_RELEASE, 'h155, 1, 0, ST_RANGE);
    add_row(KIND_OCCUPY,  0,     0, 0, ST_OK);

    repeat (2) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (dir_rows[i]) send_beat(dir_rows[i].beat, dir_rows[i].typed, dir_rows[i].want);
    wait_drained();

    for (int unsigned seg = 0; seg < RAND_SEGMENTS; seg++) begin
      send_idle = idle_send[seg % 4];
      recv_stall = idle_recv[seg % 4];
      for (int unsigned n = 0; n < SEGMENT_BEATS; n++) begin
        b = random_beat(occupy_pct[seg]);
        send_beat(b, 1'b0, none);
      end
      // hold off until the pipe is empty between segments
      wait_drained();
    end

    recv_stall = 0;
    repeat (8) @(negedge clk);
    if (fail_count == 0) begin
      $display("lifo_free_list_slot_allocator_unit verification clean");
    end else begin
      $display("lifo_free_list_slot_allocator_unit verification failed");
    end
    $finish;
  end

endmodule

FILE: lifo_free_list_slot_allocator_unit.f
+incdir+rtl
rtl/lfsa_pkg.sv
rtl/lifo_free_list_slot_allocator_unit.sv
rtl/lfsa_checker.sv
bench/lifo_free_list_slot_allocator_unit_tb.sv
